@@ src/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Shared constants, types and codes for the pending signal aggregator.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int SIGNAL_COUNT = 16;
    localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MASK_W       = SIGNAL_COUNT;
    localparam int COUNT_W      = 5;

    typedef enum logic
    {
        MODE_RAISE = 1'b0,
        MODE_POLL  = 1'b1
    } mode_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    typedef struct packed
    {
        logic              raise;
        logic              search;
        logic [SLOT_W-1:0] target;
        logic [MASK_W-1:0] set_bits;
    } cell_ctrl_t;

    typedef struct packed
    {
        logic              claim;
        logic [SLOT_W-1:0] slot;
        logic [MASK_W-1:0] map;
    } chain_t;

endpackage

@@ src/psa_item_if.sv @@
// ----------------------------------------------------------------------------
// psa_item_if
// Input channel: one raise or poll transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface psa_item_if;

    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] target_slot;
    logic [4:0] signal_number;
    logic       manager_waiting;

    modport source
    (
        output valid,
        input  ready,
        output mode,
        output target_slot,
        output signal_number,
        output manager_waiting
    );

    modport sink
    (
        input  valid,
        output ready,
        input  mode,
        input  target_slot,
        input  signal_number,
        input  manager_waiting
    );

endinterface

@@ src/psa_result_if.sv @@
// ----------------------------------------------------------------------------
// psa_result_if
// Output channel: one notification result transaction per input transaction.
// ----------------------------------------------------------------------------
interface psa_result_if;

    logic        valid;
    logic        ready;
    logic        notify_valid;
    logic [3:0]  notified_slot;
    logic [15:0] signal_map;
    logic [4:0]  pending_slots;

    modport source
    (
        output valid,
        input  ready,
        output notify_valid,
        output notified_slot,
        output signal_map,
        output pending_slots
    );

    modport sink
    (
        input  valid,
        output ready,
        input  notify_valid,
        input  notified_slot,
        input  signal_map,
        input  pending_slots
    );

endinterface

@@ src/pending_signal_aggregator.sv @@
// ----------------------------------------------------------------------------
// pending_signal_aggregator
// Keeps a pending-signal mask per process slot in a row of cells and reports
// the lowest slot with pending signals to a waiting manager.
// ----------------------------------------------------------------------------
// Channel   Modport  Transaction
// item      sink     mode, target_slot, signal_number, manager_waiting
// result    source   notify_valid, notified_slot, signal_map, pending_slots
//
// Each transaction is taken in ST_IDLE, where the raise is written into the
// cells at the accepting edge; the search along the cell chain runs in ST_SEARCH.
// The search waits while the output register still holds an untaken result.
// Reset clears all masks, the count and the output valid flag at once.
// ----------------------------------------------------------------------------
module pending_signal_aggregator
(
    input  logic         clk,
    input  logic         rst_n,
    psa_item_if.sink     item,
    psa_result_if.source result
);

    psa_pkg::state_t              state_reg;
    psa_pkg::state_t              state_next;
    logic                         waiting_reg;
    logic                         inc_reg;
    logic [psa_pkg::COUNT_W-1:0]  count_reg;
    logic [psa_pkg::COUNT_W-1:0]  count_next;
    logic                         out_valid_reg;
    logic                         notify_valid_reg;
    logic [3:0]                   notified_slot_reg;
    logic [15:0]                  signal_map_reg;
    logic [4:0]                   pending_slots_reg;

    logic                         accept;
    logic                         out_free;
    logic                         step;
    logic                         slot_ok;
    logic                         signal_ok;
    logic                         found;
    logic [psa_pkg::SLOT_COUNT-1:0] newly_vec;
    psa_pkg::cell_ctrl_t          ctrl;
    psa_pkg::chain_t              chain [psa_pkg::SLOT_COUNT+1];

    assign item.ready = (state_reg == psa_pkg::ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign step       = (state_reg == psa_pkg::ST_SEARCH) && out_free;

    assign slot_ok   = 32'(item.target_slot) < psa_pkg::SLOT_COUNT;
    assign signal_ok = (item.signal_number != 5'd0)
                    && (32'(item.signal_number) <= psa_pkg::SIGNAL_COUNT);

    always_comb
    begin
        ctrl.raise    = accept && (item.mode == psa_pkg::MODE_RAISE) && slot_ok && signal_ok;
        ctrl.search   = step && waiting_reg;
        ctrl.target   = psa_pkg::SLOT_W'(item.target_slot);
        ctrl.set_bits = psa_pkg::MASK_W'(1) << (item.signal_number - 5'd1);
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < psa_pkg::SLOT_COUNT; i++)
    begin : g_cell
        psa_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .slot_id   (psa_pkg::SLOT_W'(i)),
            .ctrl      (ctrl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .newly_set (newly_vec[i])
        );
    end

    assign found      = waiting_reg && chain[psa_pkg::SLOT_COUNT].claim;
    assign count_next = count_reg + psa_pkg::COUNT_W'(inc_reg) - psa_pkg::COUNT_W'(found);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = psa_pkg::ST_SEARCH;
                end
            end
            psa_pkg::ST_SEARCH:
            begin
                if (step)
                begin
                    state_next = psa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psa_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            waiting_reg   <= 1'b0;
            inc_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                waiting_reg <= item.manager_waiting;
                inc_reg     <= |newly_vec;
            end
            if (step)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            notify_valid_reg  <= found;
            notified_slot_reg <= found ? 4'(chain[psa_pkg::SLOT_COUNT].slot) : 4'd0;
            signal_map_reg    <= found ? 16'(chain[psa_pkg::SLOT_COUNT].map) : 16'd0;
            pending_slots_reg <= count_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.notify_valid  = notify_valid_reg;
    assign result.notified_slot = notified_slot_reg;
    assign result.signal_map    = signal_map_reg;
    assign result.pending_slots = pending_slots_reg;

`ifndef SYNTHESIS
    a_accept_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == psa_pkg::ST_SEARCH))
        else $error("Accepted transaction did not start a search.");

    a_found_map_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (step && found) |-> (chain[psa_pkg::SLOT_COUNT].map != '0))
        else $error("Reported slot has an empty mask.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= psa_pkg::SLOT_COUNT)
        else $error("Pending slot count exceeds the slot count.");

    a_step_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (out_valid_reg && (state_reg == psa_pkg::ST_IDLE)))
        else $error("Search step did not load the output register.");
`endif

endmodule

@@ src/psa_cell.sv @@
// ----------------------------------------------------------------------------
// psa_cell
// One slot of the aggregator: holds the slot's pending mask, applies raises
// and takes part in the lowest-nonzero-slot search along the chain.
// ----------------------------------------------------------------------------
module psa_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [psa_pkg::SLOT_W-1:0] slot_id,
    input  psa_pkg::cell_ctrl_t       ctrl,
    input  psa_pkg::chain_t           chain_in,
    output psa_pkg::chain_t           chain_out,
    output logic                      newly_set
);

    logic [psa_pkg::MASK_W-1:0] mask_reg;
    logic [psa_pkg::MASK_W-1:0] mask_next;
    logic                       nonzero;
    logic                       raise_hit;
    logic                       first;

    assign nonzero   = |mask_reg;
    assign raise_hit = ctrl.raise && (ctrl.target == slot_id);
    assign first     = nonzero && !chain_in.claim;
    assign newly_set = raise_hit && !nonzero;

    always_comb
    begin
        chain_out.claim = chain_in.claim || nonzero;
        chain_out.slot  = first ? slot_id : chain_in.slot;
        chain_out.map   = first ? mask_reg : chain_in.map;
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (ctrl.search && first)
        begin
            mask_next = '0;
        end
        else if (raise_hit)
        begin
            mask_next = mask_reg | ctrl.set_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

endmodule
